// ===== design/jcc_pkg.sv =====
// ============================================================================
// jcc_pkg
// Shared types and codes for the joystick calibrate and classify core.
// ============================================================================
`default_nettype none

package jcc_pkg;

   localparam int FIELD_BITS = 16;
   localparam int PORT_BITS  = 8;
   localparam int DIR_BITS   = 6;

   typedef logic [1:0]            cmd_type;
   typedef logic [2:0]            phase_type;
   typedef logic [DIR_BITS-1:0]   dir_type;
   typedef logic [FIELD_BITS-1:0] field_type;
   typedef logic [PORT_BITS-1:0]  port_type;

   // commands
   localparam cmd_type CMD_SAMPLE  = 2'd0;
   localparam cmd_type CMD_QUIT    = 2'd1;
   localparam cmd_type CMD_RESTART = 2'd2;
   localparam cmd_type CMD_START   = 2'd3;

   // calibration phases
   localparam phase_type PH_IDLE   = 3'd0;
   localparam phase_type PH_MINMAX = 3'd1;
   localparam phase_type PH_REL1   = 3'd2;
   localparam phase_type PH_CENTRE = 3'd3;
   localparam phase_type PH_REL2   = 3'd4;
   localparam phase_type PH_FINAL  = 3'd5;
   localparam phase_type PH_REL3   = 3'd6;

   // port byte bits, active low
   localparam int BTN1_BIT = 4;
   localparam int BTN2_BIT = 5;

   // direction flag positions
   localparam int DIR_LEFT  = 0;
   localparam int DIR_RIGHT = 1;
   localparam int DIR_UP    = 2;
   localparam int DIR_DOWN  = 3;
   localparam int DIR_BTN1  = 4;
   localparam int DIR_BTN2  = 5;

endpackage

`default_nettype wire

// ===== design/jcc_if.sv =====
// ============================================================================
// jcc_if
// Valid/ready channels for joystick samples and classified results.
// ============================================================================
`default_nettype none

interface jcc_req_if;
   logic                valid;
   logic                ready;
   jcc_pkg::cmd_type    command;
   jcc_pkg::field_type  axis_x;
   jcc_pkg::field_type  axis_y;
   jcc_pkg::port_type   port_status;

   modport source (output valid, output command, output axis_x, output axis_y,
                   output port_status, input ready);
   modport sink   (input valid, input command, input axis_x, input axis_y,
                   input port_status, output ready);
endinterface

interface jcc_rsp_if;
   logic                valid;
   logic                ready;
   jcc_pkg::dir_type    directions;
   jcc_pkg::phase_type  phase;
   logic                connected;
   logic                calibrating;

   modport source (output valid, output directions, output phase, output connected,
                   output calibrating, input ready);
   modport sink   (input valid, input directions, input phase, input connected,
                   input calibrating, output ready);
endinterface

`default_nettype wire

// ===== design/jcc_zone.sv =====
// ============================================================================
// jcc_zone
// Deadzone bounds of one axis from centre and tracked min/max:
// low = c - ceil(r/5) floored at 0, high = c + floor(r/5) capped at all ones.
// ============================================================================
`default_nettype none

module jcc_zone #(
   parameter int AXIS_BITS = 16
) (
   input  wire logic [AXIS_BITS-1:0] centre,
   input  wire logic [AXIS_BITS-1:0] min_val,
   input  wire logic [AXIS_BITS-1:0] max_val,
   output logic      [AXIS_BITS-1:0] dead_low,
   output logic      [AXIS_BITS-1:0] dead_high
);

   localparam int SHIFT = AXIS_BITS + 2;
   localparam int PW    = 2 * AXIS_BITS + 2;
   // reciprocal of five, rounded up; exact floor for all ranges below 2^AXIS_BITS
   localparam logic [PW-1:0] RECIP5 = PW'(((64'd1 << SHIFT) + 64'd4) / 64'd5);

   logic [AXIS_BITS-1:0] range;
   logic [PW-1:0]        prod;
   logic [AXIS_BITS-1:0] quot;
   logic [AXIS_BITS-1:0] times5;
   logic [AXIS_BITS-1:0] below;
   logic [AXIS_BITS:0]   sum;

   assign range  = (max_val >= min_val) ? (max_val - min_val) : '0;
   assign prod   = PW'(range) * RECIP5;
   assign quot   = prod[SHIFT +: AXIS_BITS];
   assign times5 = (quot << 2) + quot;
   assign below  = quot + AXIS_BITS'(range != times5);
   assign sum    = {1'b0, centre} + {1'b0, quot};

   assign dead_low  = (centre >= below) ? (centre - below) : '0;
   assign dead_high = sum[AXIS_BITS] ? '1 : sum[AXIS_BITS-1:0];

endmodule

`default_nettype wire

// ===== design/jcc_classify.sv =====
// ============================================================================
// jcc_classify
// Direction and button flags of one sample against the deadzone.
// ============================================================================
`default_nettype none

module jcc_classify #(
   parameter int AXIS_BITS = 16
) (
   input  wire logic [AXIS_BITS-1:0] axis_x,
   input  wire logic [AXIS_BITS-1:0] axis_y,
   input  wire logic [AXIS_BITS-1:0] dead_low_x,
   input  wire logic [AXIS_BITS-1:0] dead_high_x,
   input  wire logic [AXIS_BITS-1:0] dead_low_y,
   input  wire logic [AXIS_BITS-1:0] dead_high_y,
   input  wire logic                 connected,
   input  wire logic                 btn1,
   input  wire logic                 btn2,
   output jcc_pkg::dir_type          directions
);

   always_comb begin
      directions = '0;
      if (connected) begin
         directions[jcc_pkg::DIR_LEFT]  = axis_x < dead_low_x;
         directions[jcc_pkg::DIR_RIGHT] = axis_x > dead_high_x;
         directions[jcc_pkg::DIR_UP]    = axis_y < dead_low_y;
         directions[jcc_pkg::DIR_DOWN]  = axis_y > dead_high_y;
         directions[jcc_pkg::DIR_BTN1]  = btn1;
         directions[jcc_pkg::DIR_BTN2]  = btn2;
      end
   end

endmodule

`default_nettype wire

// ===== design/joystick_calibrate_and_classify_core.sv =====
// ============================================================================
// joystick_calibrate_and_classify_core
// Joystick calibration sequencer with deadzone setup and direction flags.
//
//   channel | dir | contents
//   --------+-----+-----------------------------------------------------
//   req_bus | in  | command, axis_x, axis_y, port_status
//   rsp_bus | out | directions, phase, connected, calibrating
//
// One request per cycle sustained while responses are taken; a request is
// captured in the input register at acceptance, and its response is written
// into the response register as it leaves and is offered from there.
// Calibration state updates as a request moves into the response register.
// A stalled response holds; one more request is still taken into the input
// register. Synchronous reset clears phase, min/max, deadzone and connection.
// ============================================================================
`default_nettype none

module joystick_calibrate_and_classify_core #(
   parameter int AXIS_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   jcc_req_if.sink   req_bus,
   jcc_rsp_if.source rsp_bus
);

   localparam int AB = AXIS_BITS;

   // input stage
   logic                 s1_valid_ff;
   jcc_pkg::cmd_type     s1_cmd_ff;
   logic [AB-1:0]        s1_x_ff;
   logic [AB-1:0]        s1_y_ff;
   logic                 s1_b1_ff;
   logic                 s1_b2_ff;

   // response stage
   logic                 rsp_valid_ff;
   jcc_pkg::dir_type     rsp_dirs_ff;
   jcc_pkg::phase_type   rsp_phase_ff;
   logic                 rsp_conn_ff;
   logic                 rsp_cal_ff;

   // calibration state
   jcc_pkg::phase_type   phase_ff,  phase_in;
   logic [AB-1:0]        min_x_ff,  min_x_in;
   logic [AB-1:0]        max_x_ff,  max_x_in;
   logic [AB-1:0]        min_y_ff,  min_y_in;
   logic [AB-1:0]        max_y_ff,  max_y_in;
   logic [AB-1:0]        dlx_ff,    dlx_in;
   logic [AB-1:0]        dhx_ff,    dhx_in;
   logic [AB-1:0]        dly_ff,    dly_in;
   logic [AB-1:0]        dhy_ff,    dhy_in;
   logic                 conn_ff,   conn_in;

   logic                 advance;
   logic                 fire;
   logic                 req_accept;
   jcc_pkg::phase_type   phase_cur;
   jcc_pkg::phase_type   phase_run;
   logic                 zone_load;
   logic [AB-1:0]        zlx, zhx, zly, zhy;
   jcc_pkg::dir_type     dirs;

   assign advance         = !rsp_valid_ff || rsp_bus.ready;
   assign fire            = s1_valid_ff && advance;
   assign req_bus.ready   = !s1_valid_ff || advance;
   assign req_accept      = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff <= req_bus.command;
         s1_x_ff   <= req_bus.axis_x[AB-1:0];
         s1_y_ff   <= req_bus.axis_y[AB-1:0];
         s1_b1_ff  <= !req_bus.port_status[jcc_pkg::BTN1_BIT];
         s1_b2_ff  <= !req_bus.port_status[jcc_pkg::BTN2_BIT];
      end
   end

   jcc_zone #(.AXIS_BITS(AB)) u_zone_x (
      .centre    (s1_x_ff),
      .min_val   (min_x_ff),
      .max_val   (max_x_ff),
      .dead_low  (zlx),
      .dead_high (zhx)
   );

   jcc_zone #(.AXIS_BITS(AB)) u_zone_y (
      .centre    (s1_y_ff),
      .min_val   (min_y_ff),
      .max_val   (max_y_ff),
      .dead_low  (zly),
      .dead_high (zhy)
   );

   always_comb begin
      phase_cur = (phase_ff > jcc_pkg::PH_REL3) ? jcc_pkg::PH_IDLE : phase_ff;
      phase_run = phase_cur;
      phase_in  = phase_cur;
      min_x_in  = min_x_ff;
      max_x_in  = max_x_ff;
      min_y_in  = min_y_ff;
      max_y_in  = max_y_ff;
      zone_load = 1'b0;
      conn_in   = conn_ff;
      if (s1_cmd_ff == jcc_pkg::CMD_START) begin
         if (s1_x_ff == '0 && s1_y_ff == '0) begin
            phase_in = jcc_pkg::PH_IDLE;
         end else begin
            min_x_in = s1_x_ff;
            max_x_in = s1_x_ff;
            min_y_in = s1_y_ff;
            max_y_in = s1_y_ff;
            phase_in = jcc_pkg::PH_MINMAX;
         end
      end else if (phase_cur != jcc_pkg::PH_IDLE) begin
         if (s1_cmd_ff == jcc_pkg::CMD_RESTART) begin
            phase_run = jcc_pkg::PH_MINMAX;
         end
         phase_in = phase_run;
         case (phase_run)
            jcc_pkg::PH_MINMAX: begin
               if (s1_x_ff > max_x_ff) max_x_in = s1_x_ff;
               if (s1_y_ff > max_y_ff) max_y_in = s1_y_ff;
               if (s1_x_ff < min_x_ff) min_x_in = s1_x_ff;
               if (s1_y_ff < min_y_ff) min_y_in = s1_y_ff;
               if (s1_b1_ff) phase_in = jcc_pkg::PH_REL1;
            end
            jcc_pkg::PH_REL1: begin
               if (!s1_b1_ff) phase_in = jcc_pkg::PH_CENTRE;
            end
            jcc_pkg::PH_CENTRE: begin
               if (s1_b1_ff) begin
                  phase_in  = jcc_pkg::PH_REL2;
                  zone_load = 1'b1;
                  conn_in   = 1'b1;
               end
            end
            jcc_pkg::PH_REL2: begin
               if (!s1_b1_ff) phase_in = jcc_pkg::PH_FINAL;
            end
            jcc_pkg::PH_FINAL: begin
               if (s1_b1_ff) phase_in = jcc_pkg::PH_REL3;
            end
            jcc_pkg::PH_REL3: begin
               if (!s1_b1_ff) phase_in = jcc_pkg::PH_IDLE;
            end
            default: begin
               phase_in = jcc_pkg::PH_IDLE;
            end
         endcase
         if (s1_cmd_ff == jcc_pkg::CMD_QUIT) begin
            phase_in = jcc_pkg::PH_IDLE;
         end
      end
   end

   assign dlx_in = zone_load ? zlx : dlx_ff;
   assign dhx_in = zone_load ? zhx : dhx_ff;
   assign dly_in = zone_load ? zly : dly_ff;
   assign dhy_in = zone_load ? zhy : dhy_ff;

   jcc_classify #(.AXIS_BITS(AB)) u_classify (
      .axis_x      (s1_x_ff),
      .axis_y      (s1_y_ff),
      .dead_low_x  (dlx_in),
      .dead_high_x (dhx_in),
      .dead_low_y  (dly_in),
      .dead_high_y (dhy_in),
      .connected   (conn_in),
      .btn1        (s1_b1_ff),
      .btn2        (s1_b2_ff),
      .directions  (dirs)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jcc_pkg::PH_IDLE;
         min_x_ff <= '0;
         max_x_ff <= '0;
         min_y_ff <= '0;
         max_y_ff <= '0;
         dlx_ff   <= '0;
         dhx_ff   <= '0;
         dly_ff   <= '0;
         dhy_ff   <= '0;
         conn_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         min_x_ff <= min_x_in;
         max_x_ff <= max_x_in;
         min_y_ff <= min_y_in;
         max_y_ff <= max_y_in;
         dlx_ff   <= dlx_in;
         dhx_ff   <= dhx_in;
         dly_ff   <= dly_in;
         dhy_ff   <= dhy_in;
         conn_ff  <= conn_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_dirs_ff  <= dirs;
         rsp_phase_ff <= phase_in;
         rsp_conn_ff  <= conn_in;
         rsp_cal_ff   <= phase_in != jcc_pkg::PH_IDLE;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.directions  = rsp_dirs_ff;
   assign rsp_bus.phase       = rsp_phase_ff;
   assign rsp_bus.connected   = rsp_conn_ff;
   assign rsp_bus.calibrating = rsp_cal_ff;

   // connection is sticky until reset
   a_conn_sticky: assert property (@(posedge clock) disable iff (reset)
      conn_ff |=> conn_ff)
      else $error("connection flag dropped");

   // no flags before a centre was taken
   a_dirs_gated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_conn_ff |-> rsp_dirs_ff == '0)
      else $error("direction flags while not connected");

   a_cal_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_cal_ff == (rsp_phase_ff != jcc_pkg::PH_IDLE))
      else $error("calibrating flag disagrees with phase");

   // a blocked input stage keeps its request
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff)
      else $error("input stage request lost while stalled");

   // state only moves with a request leaving the input stage
   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(phase_ff) && $stable(conn_ff))
      else $error("calibration state changed without a request");

endmodule

`default_nettype wire

// ===== dv/tb_joystick_calibrate_and_classify_core.sv =====
// ============================================================================
// tb_joystick_calibrate_and_classify_core
// Self-checking bench for the joystick calibrate and classify core. Directed
// tests walk the calibration phases, the command corner cases and deadzone
// saturation. Random tests then run many calibrations with random content
// mixed with noise. A local tracker of the calibration state predicts every
// response, and each response is compared field by field in request order.
// Both channels stall at random, and the response side holds off long enough
// to back the core up.
// ============================================================================

module tb_joystick_calibrate_and_classify_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AXIS_BITS      = 16;
   localparam int AXIS_MAX       = (1 << AXIS_BITS) - 1;
   localparam int ITEM_TARGET    = 1200;
   localparam int HOLDOFF_CYCLES = 40;
   localparam int DRAIN_CYCLES   = 8;
   localparam int CYCLE_LIMIT    = 100000;

   typedef struct packed {
      jcc_pkg::cmd_type   command;
      jcc_pkg::field_type axis_x;
      jcc_pkg::field_type axis_y;
      jcc_pkg::port_type  port_status;
   } joy_sample_type;

   typedef struct packed {
      jcc_pkg::dir_type   directions;
      jcc_pkg::phase_type phase;
      logic               connected;
      logic               calibrating;
   } joy_status_type;

   logic clock;
   logic reset;

   jcc_req_if req_bus ();
   jcc_rsp_if rsp_bus ();

   joystick_calibrate_and_classify_core #(
      .AXIS_BITS (AXIS_BITS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // calibration tracker
   jcc_pkg::phase_type trk_phase;
   jcc_pkg::field_type trk_min_x, trk_max_x, trk_min_y, trk_max_y;
   jcc_pkg::field_type zone_lo_x, zone_hi_x, zone_lo_y, zone_hi_y;
   logic               trk_connected;

   joy_status_type status_q[$];

   int  requests_sent;
   int  results_checked;
   int  errors;
   int  zone_sets;
   int  cal_finishes;
   int  cycle_count;
   bit  steady;
   bit  holdoff_request;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, status_q.size());
            $display("** joystick_calibrate_and_classify_core: FAILED **");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic void compute_zone(input int centre, input int lo, input int hi,
                                        output jcc_pkg::field_type zlo,
                                        output jcc_pkg::field_type zhi);
      int span;
      int below;
      int above;
      span  = (hi >= lo) ? hi - lo : 0;
      below = (span + 4) / 5;
      above = span / 5;
      zlo   = jcc_pkg::field_type'((centre >= below) ? centre - below : 0);
      zhi   = jcc_pkg::field_type'((centre + above > AXIS_MAX) ? AXIS_MAX : centre + above);
   endfunction

   function automatic joy_status_type classify_sample(joy_sample_type s);
      jcc_pkg::field_type x;
      jcc_pkg::field_type y;
      logic               b1;
      logic               b2;
      logic               ended;
      joy_status_type     st;
      x     = s.axis_x & jcc_pkg::field_type'(AXIS_MAX);
      y     = s.axis_y & jcc_pkg::field_type'(AXIS_MAX);
      b1    = !s.port_status[jcc_pkg::BTN1_BIT];
      b2    = !s.port_status[jcc_pkg::BTN2_BIT];
      ended = 1'b0;
      st    = '0;

      if (trk_phase > jcc_pkg::PH_REL3) trk_phase = jcc_pkg::PH_IDLE;

      if (s.command == jcc_pkg::CMD_START) begin
         if (x == 0 && y == 0) begin
            trk_phase = jcc_pkg::PH_IDLE;
         end else begin
            trk_min_x = x;
            trk_max_x = x;
            trk_min_y = y;
            trk_max_y = y;
            trk_phase = jcc_pkg::PH_MINMAX;
         end
      end else if (trk_phase != jcc_pkg::PH_IDLE) begin
         if (s.command == jcc_pkg::CMD_RESTART) trk_phase = jcc_pkg::PH_MINMAX;
         case (trk_phase)
            jcc_pkg::PH_MINMAX: begin
               if (x > trk_max_x) trk_max_x = x;
               if (y > trk_max_y) trk_max_y = y;
               if (x < trk_min_x) trk_min_x = x;
               if (y < trk_min_y) trk_min_y = y;
               if (b1) trk_phase = jcc_pkg::PH_REL1;
            end
            jcc_pkg::PH_REL1: if (!b1) trk_phase = jcc_pkg::PH_CENTRE;
            jcc_pkg::PH_CENTRE: begin
               if (b1) begin
                  trk_phase = jcc_pkg::PH_REL2;
                  compute_zone(x, trk_min_x, trk_max_x, zone_lo_x, zone_hi_x);
                  compute_zone(y, trk_min_y, trk_max_y, zone_lo_y, zone_hi_y);
                  trk_connected = 1'b1;
                  zone_sets++;
               end
            end
            jcc_pkg::PH_REL2: if (!b1) trk_phase = jcc_pkg::PH_FINAL;
            jcc_pkg::PH_FINAL: if (b1) trk_phase = jcc_pkg::PH_REL3;
            jcc_pkg::PH_REL3: begin
               if (!b1) begin
                  ended = 1'b1;
                  cal_finishes++;
               end
            end
            default: ;
         endcase
         if (ended || s.command == jcc_pkg::CMD_QUIT) trk_phase = jcc_pkg::PH_IDLE;
      end

      if (trk_connected) begin
         st.directions[jcc_pkg::DIR_LEFT]  = x < zone_lo_x;
         st.directions[jcc_pkg::DIR_RIGHT] = x > zone_hi_x;
         st.directions[jcc_pkg::DIR_UP]    = y < zone_lo_y;
         st.directions[jcc_pkg::DIR_DOWN]  = y > zone_hi_y;
         st.directions[jcc_pkg::DIR_BTN1]  = b1;
         st.directions[jcc_pkg::DIR_BTN2]  = b2;
      end
      st.phase       = trk_phase;
      st.connected   = trk_connected;
      st.calibrating = trk_phase != jcc_pkg::PH_IDLE;
      return st;
   endfunction

   // ---------------------------------------------------------------- request side

   task automatic send_sample(input jcc_pkg::cmd_type cmd, input int x, input int y,
                              input jcc_pkg::port_type port);
      joy_sample_type s;
      s.command     = cmd;
      s.axis_x      = jcc_pkg::field_type'(x);
      s.axis_y      = jcc_pkg::field_type'(y);
      s.port_status = port;
      if (!steady) begin
         while ($urandom_range(99) < 6) begin
            req_bus.valid = 1'b0;
            @(negedge clock);
         end
      end
      req_bus.valid       = 1'b1;
      req_bus.command     = s.command;
      req_bus.axis_x      = s.axis_x;
      req_bus.axis_y      = s.axis_y;
      req_bus.port_status = s.port_status;
      do @(posedge clock); while (!req_bus.ready);
      status_q.push_back(classify_sample(s));
      requests_sent++;
      @(negedge clock);
   endtask

   function automatic int random_axis();
      int r;
      r = $urandom_range(99);
      if (r < 10) return $urandom_range(15);
      if (r < 20) return AXIS_MAX - $urandom_range(15);
      if (r < 35) return (32768 + $urandom_range(2048) - 1024) & AXIS_MAX;
      return $urandom_range(AXIS_MAX);
   endfunction

   function automatic jcc_pkg::port_type port_byte(bit pressed);
      jcc_pkg::port_type p;
      p = jcc_pkg::port_type'($urandom_range(255));
      p[jcc_pkg::BTN1_BIT] = !pressed;
      return p;
   endfunction

   // mostly plain samples, with the odd command breaking the sequence
   function automatic jcc_pkg::cmd_type sequence_cmd();
      int r;
      r = $urandom_range(99);
      if (r < 3) return jcc_pkg::CMD_QUIT;
      if (r < 6) return jcc_pkg::CMD_RESTART;
      if (r < 8) return jcc_pkg::CMD_START;
      return jcc_pkg::CMD_SAMPLE;
   endfunction

   task automatic hold_button(input bit pressed);
      repeat ($urandom_range(1, 3))
         send_sample(sequence_cmd(), random_axis(), random_axis(), port_byte(pressed));
   endtask

   // ---------------------------------------------------------------- response side

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_request) begin
            holdoff_request = 1'b0;
            rsp_bus.ready   = 1'b0;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
         end else begin
            rsp_bus.ready = steady || ($urandom_range(99) >= 6);
         end
      end
   end

   task automatic report_field(input string name, input int want, input int got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
   endtask

   always @(posedge clock) begin
      joy_status_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (status_q.size() == 0) begin
            report_field("unexpected response, phase", -1, rsp_bus.phase);
         end else begin
            want = status_q.pop_front();
            results_checked++;
            if (rsp_bus.directions !== want.directions)
               report_field("directions", want.directions, rsp_bus.directions);
            if (rsp_bus.phase !== want.phase)
               report_field("phase", want.phase, rsp_bus.phase);
            if (rsp_bus.connected !== want.connected)
               report_field("connected", want.connected, rsp_bus.connected);
            if (rsp_bus.calibrating !== want.calibrating)
               report_field("calibrating", want.calibrating, rsp_bus.calibrating);
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_idle_commands();
      send_sample(jcc_pkg::CMD_SAMPLE,  0, 0, 8'h00);
      send_sample(jcc_pkg::CMD_QUIT,    AXIS_MAX, AXIS_MAX, 8'hEF);
      send_sample(jcc_pkg::CMD_RESTART, 16'h8000, 16'h8000, 8'hCF);
      send_sample(jcc_pkg::CMD_START,   0, 0, 8'hFF);
   endtask

   task automatic test_calibration_sequence();
      send_sample(jcc_pkg::CMD_START,  16'h8000, 16'h8000, 8'hFF);
      send_sample(jcc_pkg::CMD_SAMPLE, 16'h7000, 16'h9000, 8'hFF);
      send_sample(jcc_pkg::CMD_SAMPLE, 16'h9000, 16'h7000, 8'hFF);
      send_sample(jcc_pkg::CMD_SAMPLE, 16'h8000, 16'h8000, 8'hEF);
      send_sample(jcc_pkg::CMD_SAMPLE, 16'h8000, 16'h8000, 8'hFF);
      send_sample(jcc_pkg::CMD_SAMPLE, 16'h8000, 16'h8000, 8'hEF);
      send_sample(jcc_pkg::CMD_SAMPLE, 0, 0, 8'h00);
      send_sample(jcc_pkg::CMD_SAMPLE, AXIS_MAX, AXIS_MAX, 8'hCF);
      send_sample(jcc_pkg::CMD_SAMPLE, 16'h8000, 16'h8000, 8'hFF);
      send_sample(jcc_pkg::CMD_SAMPLE, 16'h8000, 16'h8000, 8'hEF);
      send_sample(jcc_pkg::CMD_SAMPLE, 16'h8000, 16'h8000, 8'hFF);
   endtask

   // centre near both ends of the axis with a full range
   task automatic test_zone_saturation();
      send_sample(jcc_pkg::CMD_START,  5, AXIS_MAX - 5, 8'hFF);
      send_sample(jcc_pkg::CMD_SAMPLE, 0, 0, 8'hFF);
      send_sample(jcc_pkg::CMD_SAMPLE, AXIS_MAX, AXIS_MAX, 8'hEF);
      send_sample(jcc_pkg::CMD_SAMPLE, 5, AXIS_MAX - 5, 8'hFF);
      send_sample(jcc_pkg::CMD_SAMPLE, 5, AXIS_MAX - 5, 8'hEF);
      send_sample(jcc_pkg::CMD_QUIT,   0, AXIS_MAX, 8'hEF);
   endtask

   task automatic test_command_interplay();
      send_sample(jcc_pkg::CMD_START,   100, 200, 8'hFF);
      send_sample(jcc_pkg::CMD_SAMPLE,  100, 200, 8'hEF);
      send_sample(jcc_pkg::CMD_RESTART, 300, 50, 8'hEF);
      send_sample(jcc_pkg::CMD_START,   0, 0, 8'hEF);
      send_sample(jcc_pkg::CMD_START,   1, 0, 8'hFF);
      send_sample(jcc_pkg::CMD_QUIT,    0, 9, 8'hEF);
   endtask

   task automatic test_response_holdoff();
      steady          = 1'b1;
      holdoff_request = 1'b1;
      repeat (12)
         send_sample(jcc_pkg::CMD_SAMPLE, random_axis(), random_axis(),
                     port_byte($urandom_range(1)));
      steady = 1'b0;
   endtask

   task automatic run_random_calibration();
      int x;
      int y;
      x = random_axis();
      y = random_axis();
      if (x == 0 && y == 0) x = 1;
      send_sample(jcc_pkg::CMD_START, x, y, port_byte(1'b0));
      repeat ($urandom_range(0, 6))
         send_sample(sequence_cmd(), random_axis(), random_axis(), port_byte(1'b0));
      hold_button(1'b1);
      hold_button(1'b0);
      hold_button(1'b1);
      hold_button(1'b0);
      hold_button(1'b1);
      hold_button(1'b0);
      repeat ($urandom_range(0, 3))
         send_sample(jcc_pkg::CMD_SAMPLE, random_axis(), random_axis(),
                     port_byte($urandom_range(1)));
   endtask

   task automatic test_random_traffic();
      int holdoff_mark;
      holdoff_mark = requests_sent + 300;
      while (requests_sent < ITEM_TARGET) begin
         if (requests_sent >= holdoff_mark) begin
            holdoff_request = 1'b1;
            holdoff_mark += 400;
         end
         steady = (requests_sent >= 600 && requests_sent < 800);
         if ($urandom_range(99) < 80) begin
            run_random_calibration();
         end else begin
            repeat ($urandom_range(1, 8))
               send_sample(jcc_pkg::cmd_type'($urandom_range(3)), random_axis(),
                           random_axis(), jcc_pkg::port_type'($urandom_range(255)));
         end
      end
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------- main

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.command     = jcc_pkg::CMD_SAMPLE;
      req_bus.axis_x      = '0;
      req_bus.axis_y      = '0;
      req_bus.port_status = 8'hFF;
      trk_phase           = jcc_pkg::PH_IDLE;
      trk_min_x           = '0;
      trk_max_x           = '0;
      trk_min_y           = '0;
      trk_max_y           = '0;
      zone_lo_x           = '0;
      zone_hi_x           = '0;
      zone_lo_y           = '0;
      zone_hi_y           = '0;
      trk_connected       = 1'b0;
      requests_sent       = 0;
      results_checked     = 0;
      errors              = 0;
      zone_sets           = 0;
      cal_finishes        = 0;
      steady              = 1'b0;
      holdoff_request     = 1'b0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_commands();
      test_calibration_sequence();
      test_zone_saturation();
      test_command_interplay();
      test_response_holdoff();
      test_random_traffic();

      req_bus.valid = 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests, checked %0d responses, %0d mismatches",
               requests_sent, results_checked, errors);
      $display("Deadzone set %0d times, %0d calibrations ran to the last release",
               zone_sets, cal_finishes);
      if (errors == 0) begin
         $display("** joystick_calibrate_and_classify_core: PASSED **");
      end else begin
         $display("** joystick_calibrate_and_classify_core: FAILED **");
      end
      $finish;
   end

endmodule

// ===== joystick_calibrate_and_classify_core.f =====
design/jcc_pkg.sv
design/jcc_if.sv
design/jcc_zone.sv
design/jcc_classify.sv
design/joystick_calibrate_and_classify_core.sv
dv/tb_joystick_calibrate_and_classify_core.sv
